// ===== rtl/jslg_pkg.sv =====
// ============================================================================
// jslg_pkg: shared types and constants of the joint soft-limit command guard
// Field widths, register map, limit-state codes and reset values.
// ============================================================================
package jslg_pkg;

    localparam int DATA_W    = 32;   // signed Q16.16 fields
    localparam int GAIN_W    = 31;   // unsigned Q15.16 limits and gains
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;    // eight 32-bit registers
    localparam int REG_IDX_W = 3;
    localparam int EDGE_W    = 34;   // limit + margin + hysteresis, no wrap

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_POSITION_MIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POSITION_MAX    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VELOCITY_MAX    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EFFORT_MAX      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STIFFNESS_MAX   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING_MAX     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN_WIDTH    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_HYSTERESIS = 3'd7;

    // Soft-limit state codes
    localparam logic [1:0] ST_OPERATIONAL = 2'd0;
    localparam logic [1:0] ST_NEAR_LOWER  = 2'd1;
    localparam logic [1:0] ST_NEAR_UPPER  = 2'd2;
    localparam logic [1:0] ST_OVER_LIMIT  = 2'd3;

    // Register reset values
    localparam logic signed [DATA_W-1:0] RST_POSITION_MIN    = -32'sd205887;
    localparam logic signed [DATA_W-1:0] RST_POSITION_MAX    = 32'sd205887;
    localparam logic [GAIN_W-1:0]        RST_VELOCITY_MAX    = 31'd655360;
    localparam logic [GAIN_W-1:0]        RST_EFFORT_MAX      = 31'd131072;
    localparam logic [GAIN_W-1:0]        RST_STIFFNESS_MAX   = 31'd6553600;
    localparam logic [GAIN_W-1:0]        RST_DAMPING_MAX     = 31'd327680;
    localparam logic [GAIN_W-1:0]        RST_MARGIN_WIDTH    = 31'd6554;
    localparam logic [GAIN_W-1:0]        RST_EXIT_HYSTERESIS = 31'd3277;

    typedef struct packed {
        logic signed [DATA_W-1:0] position_min;
        logic signed [DATA_W-1:0] position_max;
        logic [GAIN_W-1:0]        velocity_max;
        logic [GAIN_W-1:0]        effort_max;
        logic [GAIN_W-1:0]        stiffness_max;
        logic [GAIN_W-1:0]        damping_max;
        logic [GAIN_W-1:0]        margin_width;
        logic [GAIN_W-1:0]        exit_hysteresis;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] meas_position;
        logic signed [DATA_W-1:0] meas_velocity;
        logic signed [DATA_W-1:0] req_position;
        logic signed [DATA_W-1:0] req_velocity;
        logic signed [DATA_W-1:0] req_stiffness;
        logic signed [DATA_W-1:0] req_damping;
        logic signed [DATA_W-1:0] req_torque;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_position;
        logic signed [DATA_W-1:0] out_velocity;
        logic [GAIN_W-1:0]        out_stiffness;
        logic [GAIN_W-1:0]        out_damping;
        logic signed [DATA_W-1:0] out_torque;
        logic [1:0]               limit_state;
    } out_item_t;

endpackage

// ===== rtl/jslg_in_if.sv =====
// ============================================================================
// jslg_in_if: command input channel
// Valid/ready channel carrying measured state and requested commands.
// ============================================================================
interface jslg_in_if
    import jslg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] meas_position;
    logic signed [DATA_W-1:0] meas_velocity;
    logic signed [DATA_W-1:0] req_position;
    logic signed [DATA_W-1:0] req_velocity;
    logic signed [DATA_W-1:0] req_stiffness;
    logic signed [DATA_W-1:0] req_damping;
    logic signed [DATA_W-1:0] req_torque;

    modport source (
        output valid, meas_position, meas_velocity, req_position, req_velocity,
               req_stiffness, req_damping, req_torque,
        input  ready
    );
    modport sink (
        input  valid, meas_position, meas_velocity, req_position, req_velocity,
               req_stiffness, req_damping, req_torque,
        output ready
    );
endinterface

// ===== rtl/jslg_out_if.sv =====
// ============================================================================
// jslg_out_if: guarded command output channel
// Valid/ready channel carrying guarded commands and the soft-limit state.
// ============================================================================
interface jslg_out_if
    import jslg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_position;
    logic signed [DATA_W-1:0] out_velocity;
    logic [GAIN_W-1:0]        out_stiffness;
    logic [GAIN_W-1:0]        out_damping;
    logic signed [DATA_W-1:0] out_torque;
    logic [1:0]               limit_state;

    modport source (
        output valid, out_position, out_velocity, out_stiffness, out_damping,
               out_torque, limit_state,
        input  ready
    );
    modport sink (
        input  valid, out_position, out_velocity, out_stiffness, out_damping,
               out_torque, limit_state,
        output ready
    );
endinterface

// ===== rtl/jslg_cfg_regs.sv =====
// ============================================================================
// jslg_cfg_regs: APB configuration register file
// Eight limit registers, written in the APB access phase, read back directly.
// ============================================================================
module jslg_cfg_regs
    import jslg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_POSITION_MIN:    cfg_next.position_min    = pwdata;
                REG_POSITION_MAX:    cfg_next.position_max    = pwdata;
                REG_VELOCITY_MAX:    cfg_next.velocity_max    = pwdata[GAIN_W-1:0];
                REG_EFFORT_MAX:      cfg_next.effort_max      = pwdata[GAIN_W-1:0];
                REG_STIFFNESS_MAX:   cfg_next.stiffness_max   = pwdata[GAIN_W-1:0];
                REG_DAMPING_MAX:     cfg_next.damping_max     = pwdata[GAIN_W-1:0];
                REG_MARGIN_WIDTH:    cfg_next.margin_width    = pwdata[GAIN_W-1:0];
                REG_EXIT_HYSTERESIS: cfg_next.exit_hysteresis = pwdata[GAIN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POSITION_MIN:    prdata = cfg_reg.position_min;
            REG_POSITION_MAX:    prdata = cfg_reg.position_max;
            REG_VELOCITY_MAX:    prdata = {1'b0, cfg_reg.velocity_max};
            REG_EFFORT_MAX:      prdata = {1'b0, cfg_reg.effort_max};
            REG_STIFFNESS_MAX:   prdata = {1'b0, cfg_reg.stiffness_max};
            REG_DAMPING_MAX:     prdata = {1'b0, cfg_reg.damping_max};
            REG_MARGIN_WIDTH:    prdata = {1'b0, cfg_reg.margin_width};
            REG_EXIT_HYSTERESIS: prdata = {1'b0, cfg_reg.exit_hysteresis};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_min    <= RST_POSITION_MIN;
            cfg_reg.position_max    <= RST_POSITION_MAX;
            cfg_reg.velocity_max    <= RST_VELOCITY_MAX;
            cfg_reg.effort_max      <= RST_EFFORT_MAX;
            cfg_reg.stiffness_max   <= RST_STIFFNESS_MAX;
            cfg_reg.damping_max     <= RST_DAMPING_MAX;
            cfg_reg.margin_width    <= RST_MARGIN_WIDTH;
            cfg_reg.exit_hysteresis <= RST_EXIT_HYSTERESIS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/jslg_limit_fsm.sv =====
// ============================================================================
// jslg_limit_fsm: four-state soft-limit machine
// Classify measured position and velocity against limits, margin and exit
// hysteresis; commit the new state when the item advances.
// ============================================================================
module jslg_limit_fsm
    import jslg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  cfg_t                     cfg,
    input  logic signed [DATA_W-1:0] meas_position,
    input  logic signed [DATA_W-1:0] meas_velocity,
    output logic [1:0]               state_new
);

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic signed [EDGE_W-1:0] pos_w;
    logic signed [EDGE_W-1:0] lim_lo;
    logic signed [EDGE_W-1:0] lim_hi;
    logic signed [EDGE_W-1:0] margin_w;
    logic signed [EDGE_W-1:0] hyst_w;
    logic signed [EDGE_W-1:0] low_edge;
    logic signed [EDGE_W-1:0] high_edge;
    logic signed [EDGE_W-1:0] low_exit;
    logic signed [EDGE_W-1:0] high_exit;
    logic                     vel_neg;
    logic                     vel_pos;

    // Sign-extend positions to the edge width, zero-extend margins: no wrap
    assign pos_w     = EDGE_W'(meas_position);
    assign lim_lo    = EDGE_W'(cfg.position_min);
    assign lim_hi    = EDGE_W'(cfg.position_max);
    assign margin_w  = $signed({(EDGE_W-GAIN_W)'(0), cfg.margin_width});
    assign hyst_w    = $signed({(EDGE_W-GAIN_W)'(0), cfg.exit_hysteresis});
    assign low_edge  = lim_lo + margin_w;
    assign high_edge = lim_hi - margin_w;
    assign low_exit  = low_edge + hyst_w;
    assign high_exit = high_edge - hyst_w;
    assign vel_neg   = meas_velocity[DATA_W-1];
    assign vel_pos   = !meas_velocity[DATA_W-1] && (meas_velocity != '0);

    always_comb
    begin
        if (pos_w <= lim_lo || pos_w >= lim_hi)
            state_next = ST_OVER_LIMIT;
        else if (pos_w < low_edge && vel_neg)
            state_next = ST_NEAR_LOWER;
        else if (pos_w > high_edge && vel_pos)
            state_next = ST_NEAR_UPPER;
        else if (state_reg == ST_NEAR_LOWER)
            state_next = (pos_w > low_exit) ? ST_OPERATIONAL : ST_NEAR_LOWER;
        else if (state_reg == ST_NEAR_UPPER)
            state_next = (pos_w < high_exit) ? ST_OPERATIONAL : ST_NEAR_UPPER;
        else
            state_next = ST_OPERATIONAL;
    end

    assign state_new = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_OPERATIONAL;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

// ===== rtl/jslg_cmd_clamp.sv =====
// ============================================================================
// jslg_cmd_clamp: command clamping and over-limit override
// Clamp the five requested commands to their limits; in over-limit hold the
// measured position and zero the other four commands.
// ============================================================================
module jslg_cmd_clamp
    import jslg_pkg::*;
(
    input  cfg_t       cfg,
    input  in_item_t   item,
    input  logic [1:0] state_new,
    output out_item_t  result
);

    // Lower bound tested first, so with crossed bounds x below lo gives lo and any other x gives hi
    function automatic logic signed [DATA_W-1:0] clamp_s(
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] r;
        if (x < lo)
            r = lo;
        else if (x > hi)
            r = hi;
        else
            r = x;
        return r;
    endfunction

    logic signed [DATA_W-1:0] vmax_s;
    logic signed [DATA_W-1:0] emax_s;
    logic signed [DATA_W-1:0] kmax_s;
    logic signed [DATA_W-1:0] dmax_s;
    logic signed [DATA_W-1:0] c_pos;
    logic signed [DATA_W-1:0] c_vel;
    logic signed [DATA_W-1:0] c_stf;
    logic signed [DATA_W-1:0] c_dmp;
    logic signed [DATA_W-1:0] c_trq;
    logic                     over;

    assign vmax_s = $signed({1'b0, cfg.velocity_max});
    assign emax_s = $signed({1'b0, cfg.effort_max});
    assign kmax_s = $signed({1'b0, cfg.stiffness_max});
    assign dmax_s = $signed({1'b0, cfg.damping_max});

    assign c_pos = clamp_s(item.req_position, cfg.position_min, cfg.position_max);
    assign c_vel = clamp_s(item.req_velocity, -vmax_s, vmax_s);
    assign c_stf = clamp_s(item.req_stiffness, '0, kmax_s);
    assign c_dmp = clamp_s(item.req_damping, '0, dmax_s);
    assign c_trq = clamp_s(item.req_torque, -emax_s, emax_s);

    assign over = (state_new == ST_OVER_LIMIT);

    always_comb
    begin
        result.limit_state = state_new;
        if (over)
        begin
            result.out_position  = item.meas_position;
            result.out_velocity  = '0;
            result.out_stiffness = '0;
            result.out_damping   = '0;
            result.out_torque    = '0;
        end
        else
        begin
            result.out_position  = c_pos;
            result.out_velocity  = c_vel;
            result.out_stiffness = c_stf[GAIN_W-1:0];
            result.out_damping   = c_dmp[GAIN_W-1:0];
            result.out_torque    = c_trq;
        end
    end

endmodule

// ===== rtl/joint_soft_limit_command_guard.sv =====
// ============================================================================
// joint_soft_limit_command_guard: joint impedance command guard
// Clamps commands and runs a soft-limit state machine per command sample.
// ============================================================================
// Path: input register, clamp and limit logic, result register; an item
//   waits in the input register while the result register is full and
//   out_cmd.ready is low.
// Throughput: one item per cycle unless out_cmd.ready holds the result; the
//   soft-limit state commits as each item advances.
// Reset: rst_n clears both valid flags, puts the state machine in
//   operational and loads the limit registers with their defaults.
module joint_soft_limit_command_guard
    import jslg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    jslg_in_if.sink           in_cmd,
    jslg_out_if.source        out_cmd,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    in_item_t   in_item;
    in_item_t   s1_item_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    out_item_t  result;
    out_item_t  out_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_xfer;
    logic       out_free;
    logic       s1_advance;
    logic [1:0] state_new;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    jslg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or drained this
    // cycle; the input register takes a new transfer when it is empty or
    // its item moves on, so a waiting result stops input only once the
    // input register also holds an item.
    // ------------------------------------------------------------------
    assign out_free     = !out_valid_reg || out_cmd.ready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign in_cmd.ready = !s1_valid_reg || out_free;
    assign in_xfer      = in_cmd.valid && in_cmd.ready;

    assign in_item.meas_position = in_cmd.meas_position;
    assign in_item.meas_velocity = in_cmd.meas_velocity;
    assign in_item.req_position  = in_cmd.req_position;
    assign in_item.req_velocity  = in_cmd.req_velocity;
    assign in_item.req_stiffness = in_cmd.req_stiffness;
    assign in_item.req_damping   = in_cmd.req_damping;
    assign in_item.req_torque    = in_cmd.req_torque;

    always_comb
    begin
        // Hold the item until it moves to the result register
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        // Load on advance, drop once the result transfer completes
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_cmd.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // Soft-limit machine; its state commits only when an item advances,
    // so each item sees the state left by the one before it.
    // ------------------------------------------------------------------
    jslg_limit_fsm u_limit_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (s1_advance),
        .cfg           (cfg),
        .meas_position (s1_item_reg.meas_position),
        .meas_velocity (s1_item_reg.meas_velocity),
        .state_new     (state_new)
    );

    // ------------------------------------------------------------------
    // Command clamp and over-limit override
    // ------------------------------------------------------------------
    jslg_cmd_clamp u_cmd_clamp (
        .cfg       (cfg),
        .item      (s1_item_reg),
        .state_new (state_new),
        .result    (result)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= in_item;
        if (s1_advance)
            out_item_reg <= result;
    end

    // ------------------------------------------------------------------
    // Output channel
    // ------------------------------------------------------------------
    assign out_cmd.valid         = out_valid_reg;
    assign out_cmd.out_position  = out_item_reg.out_position;
    assign out_cmd.out_velocity  = out_item_reg.out_velocity;
    assign out_cmd.out_stiffness = out_item_reg.out_stiffness;
    assign out_cmd.out_damping   = out_item_reg.out_damping;
    assign out_cmd.out_torque    = out_item_reg.out_torque;
    assign out_cmd.limit_state   = out_item_reg.limit_state;

endmodule

// ===== rtl/jslg_checker.sv =====
// ============================================================================
// jslg_checker: port-level checks of the command guard
// Watches the channel handshakes and the over-limit outputs.
// ============================================================================
module jslg_checker
    import jslg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] out_position,
    input logic signed [DATA_W-1:0] out_velocity,
    input logic [GAIN_W-1:0]        out_stiffness,
    input logic [GAIN_W-1:0]        out_damping,
    input logic signed [DATA_W-1:0] out_torque,
    input logic [1:0]               limit_state
);

    // A stalled result stays valid and holds position, velocity, torque and state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_position)
            && $stable(out_velocity) && $stable(out_torque)
            && $stable(limit_state))
    else $error("stalled result changed");

    // Input stalls only when both registers are full and output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

    // An input transfer into an empty output shows a result once the item has passed the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after input transfer");

    // Over limit: all commands but position are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limit_state == ST_OVER_LIMIT |-> out_velocity == '0
            && out_stiffness == '0 && out_damping == '0 && out_torque == '0)
    else $error("nonzero command in over-limit state");

endmodule

bind joint_soft_limit_command_guard jslg_checker u_jslg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_cmd.valid),
    .in_ready      (in_cmd.ready),
    .out_valid     (out_cmd.valid),
    .out_ready     (out_cmd.ready),
    .out_position  (out_cmd.out_position),
    .out_velocity  (out_cmd.out_velocity),
    .out_stiffness (out_cmd.out_stiffness),
    .out_damping   (out_cmd.out_damping),
    .out_torque    (out_cmd.out_torque),
    .limit_state   (out_cmd.limit_state)
);
